FILE: hdl/iair_pkg.sv
// Package: sizes, command and status codes, request and result types for the array block.
`default_nettype none
package iair_pkg;

	localparam int CAPACITY = 64;
	localparam int ADDR_W = $clog2(CAPACITY);
	localparam int LEN_W = $clog2(CAPACITY + 1);

	localparam logic [2:0] CMD_READ = 3'd0;
	localparam logic [2:0] CMD_WRITE = 3'd1;
	localparam logic [2:0] CMD_INSERT = 3'd2;
	localparam logic [2:0] CMD_REMOVE = 3'd3;
	localparam logic [2:0] CMD_RESIZE = 3'd4;
	localparam logic [2:0] CMD_CLEAR = 3'd5;
	localparam logic [2:0] CMD_REALLOC = 3'd6;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [2:0] cmd;
		logic [6:0] position;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] read_value;
		logic [6:0] length;
		logic [1:0] status;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_UP,
		S_INS,
		S_DN,
		S_FIN
	} state_t;

endpackage
`default_nettype wire

FILE: hdl/indexed_array_insert_remove.sv
// Top level: ordered array of signed words with insert, remove, resize over a 1R1W store.
`default_nettype none
// Holds up to CAPACITY signed 32-bit words in a memory with one read and one write port and one
// valid flop per entry (invalid entries read as zero, so clear and reallocate need no clearing
// pass). One request is worked at a time; req_ready is high only while idle. Rejected requests,
// write, resize, clear, reallocate, append and the unused code go to the finish state and then
// to the result register; read passes a read state first. Insert before position p below length
// n shifts the elements from p up in an up state, then writes the new word in an insert state;
// remove at p below n - 1 shifts the elements above p down in a down state. The store moves one
// element per cycle through its one read port and one write port. A finished result waits in
// an output register without blocking the next request; the next result then waits for it.
module indexed_array_insert_remove (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              req_valid,
	output logic             req_ready,
	input  wire iair_pkg::req_t req,
	output logic             rsp_valid,
	input  wire              rsp_ready,
	output iair_pkg::rsp_t   rsp
);
	import iair_pkg::*;

	state_t state_q, state_d;

	logic [31:0] mem [CAPACITY];
	logic [CAPACITY-1:0] vld_q, vld_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic [ADDR_W-1:0] wa_q, wa_d;
	logic [ADDR_W-1:0] pos_a_q, pos_a_d;
	logic signed [31:0] val_q, val_d;
	logic signed [31:0] res_val_q, res_val_d;
	logic [1:0] res_st_q, res_st_d;
	logic [31:0] rd_data_q;
	logic rd_vld_q;
	logic rsp_valid_q;
	rsp_t rsp_q;

	logic mem_we, mem_re;
	logic [ADDR_W-1:0] mem_wa, mem_ra;
	logic [31:0] mem_wd;
	logic [31:0] eff;

	logic req_fire, pos_lt_len, pos_le_len, arr_full, pos_gt_cap;
	logic go_rd, go_up, go_dn, up_last, dn_last, fin_go;
	logic [ADDR_W-1:0] pos_a;
	logic [LEN_W-1:0] lm1;

	assign req_ready = (state_q == S_IDLE);
	assign req_fire = req_valid && req_ready;
	assign pos_a = req.position[ADDR_W-1:0];
	assign pos_lt_len = req.position < len_q;
	assign pos_le_len = req.position <= len_q;
	assign arr_full = len_q == LEN_W'(CAPACITY);
	assign pos_gt_cap = req.position > LEN_W'(CAPACITY);
	assign lm1 = len_q - LEN_W'(1);
	assign eff = rd_vld_q ? rd_data_q : '0;

	assign go_rd = (req.cmd == CMD_READ) && pos_lt_len;
	assign go_up = (req.cmd == CMD_INSERT) && pos_lt_len && !arr_full;
	assign go_dn = (req.cmd == CMD_REMOVE) && pos_lt_len && (req.position != lm1);
	assign up_last = wa_q == ADDR_W'(pos_a_q + 1'b1);
	assign dn_last = (LEN_W'(wa_q) + LEN_W'(2)) == len_q;
	assign fin_go = !rsp_valid_q || rsp_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					if (go_rd)
						state_d = S_RD;
					else if (go_up)
						state_d = S_UP;
					else if (go_dn)
						state_d = S_DN;
					else
						state_d = S_FIN;
				end
			end
			S_RD: state_d = S_FIN;
			S_UP: begin
				if (up_last)
					state_d = S_INS;
			end
			S_INS: state_d = S_FIN;
			S_DN: begin
				if (dn_last)
					state_d = S_FIN;
			end
			S_FIN: begin
				if (fin_go)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = wa_q;
		mem_wd = eff;
		mem_re = 1'b0;
		mem_ra = wa_q;
		vld_d = vld_q;
		len_d = len_q;
		wa_d = wa_q;
		pos_a_d = pos_a_q;
		val_d = val_q;
		res_val_d = res_val_q;
		res_st_d = res_st_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					res_val_d = '0;
					res_st_d = ST_OK;
					pos_a_d = pos_a;
					val_d = req.value;
					case (req.cmd)
						CMD_READ: begin
							if (pos_lt_len) begin
								mem_re = 1'b1;
								mem_ra = pos_a;
							end else begin
								res_st_d = ST_RANGE;
							end
						end
						CMD_WRITE: begin
							if (pos_lt_len) begin
								mem_we = 1'b1;
								mem_wa = pos_a;
								mem_wd = req.value;
								vld_d[pos_a] = 1'b1;
							end else begin
								res_st_d = ST_RANGE;
							end
						end
						CMD_INSERT: begin
							if (!pos_le_len) begin
								res_st_d = ST_RANGE;
							end else if (arr_full) begin
								res_st_d = ST_FULL;
							end else if (!pos_lt_len) begin
								// append
								mem_we = 1'b1;
								mem_wa = pos_a;
								mem_wd = req.value;
								vld_d[pos_a] = 1'b1;
								len_d = len_q + LEN_W'(1);
							end else begin
								mem_re = 1'b1;
								mem_ra = lm1[ADDR_W-1:0];
								wa_d = len_q[ADDR_W-1:0];
							end
						end
						CMD_REMOVE: begin
							if (!pos_lt_len) begin
								res_st_d = ST_RANGE;
							end else if (go_dn) begin
								mem_re = 1'b1;
								mem_ra = ADDR_W'(pos_a + 1'b1);
								wa_d = pos_a;
							end else begin
								vld_d[pos_a] = 1'b0;
								len_d = lm1;
							end
						end
						CMD_RESIZE: begin
							if (pos_gt_cap) begin
								res_st_d = ST_FULL;
							end else begin
								for (int i = 0; i < CAPACITY; i++) begin
									if (LEN_W'(i) >= req.position)
										vld_d[i] = 1'b0;
								end
								len_d = req.position;
							end
						end
						CMD_CLEAR: begin
							vld_d = '0;
							len_d = '0;
						end
						CMD_REALLOC: begin
							if (pos_gt_cap) begin
								res_st_d = ST_FULL;
							end else begin
								vld_d = '0;
								len_d = req.position;
							end
						end
						default: ;
					endcase
				end
			end
			S_RD: res_val_d = eff;
			S_UP: begin
				mem_we = 1'b1;
				vld_d[wa_q] = 1'b1;
				if (!up_last) begin
					mem_re = 1'b1;
					mem_ra = wa_q - ADDR_W'(2);
					wa_d = wa_q - ADDR_W'(1);
				end
			end
			S_INS: begin
				mem_we = 1'b1;
				mem_wa = pos_a_q;
				mem_wd = val_q;
				vld_d[pos_a_q] = 1'b1;
				len_d = len_q + LEN_W'(1);
			end
			S_DN: begin
				mem_we = 1'b1;
				vld_d[wa_q] = 1'b1;
				if (dn_last) begin
					vld_d[lm1[ADDR_W-1:0]] = 1'b0;
					len_d = lm1;
				end else begin
					mem_re = 1'b1;
					mem_ra = wa_q + ADDR_W'(2);
					wa_d = wa_q + ADDR_W'(1);
				end
			end
			S_FIN: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (mem_re) begin
			rd_data_q <= mem[mem_ra];
			rd_vld_q <= vld_q[mem_ra];
		end
	end

	always_ff @(posedge clk) begin
		wa_q <= wa_d;
		pos_a_q <= pos_a_d;
		val_q <= val_d;
		res_val_q <= res_val_d;
		res_st_q <= res_st_d;
		if (state_q == S_FIN && fin_go) begin
			rsp_q.read_value <= res_val_q;
			rsp_q.length <= len_q;
			rsp_q.status <= res_st_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			vld_q <= '0;
			len_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_q <= vld_d;
			len_q <= len_d;
			if (state_q == S_FIN && fin_go)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

`ifndef NO_ASSERTIONS
	a_len_cap: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(CAPACITY))
		else $error("length above capacity");

	a_tail_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> ((vld_q >> len_q) == '0))
		else $error("entry at or above length still valid");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> !req_ready)
		else $error("ready right after accepted request");

	a_rsp_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q == S_FIN))
		else $error("result raised outside finish state");
`endif

endmodule
`default_nettype wire

FILE: tb/indexed_array_insert_remove_tb.sv
// Testbench for the indexed array block: directed and random requests checked against a predictor.
module indexed_array_insert_remove_tb;
	import iair_pkg::*;

	localparam logic [2:0] CMD_UNUSED = 3'd7;
	localparam int STALL_LIMIT = 5000;
	localparam int ITEMS_PER_PHASE = 150;
	localparam int LONG_HOLD = 300;
	localparam int TAIL_CYCLES = 100;

	class array_scoreboard;
		logic signed [31:0] words [CAPACITY];
		int unsigned len;
		rsp_t pending [$];
		int errors;

		function new();
			foreach (words[i]) words[i] = '0;
			len = 0;
			errors = 0;
		endfunction

		function void zero_from(int unsigned start);
			for (int unsigned i = start; i < CAPACITY; i++) words[i] = '0;
		endfunction

		function void note_request(req_t r);
			rsp_t e;
			int unsigned p;
			e = '0;
			e.status = ST_OK;
			p = r.position;
			case (r.cmd)
				CMD_READ: begin
					if (p < len) e.read_value = words[p];
					else e.status = ST_RANGE;
				end
				CMD_WRITE: begin
					if (p < len) words[p] = r.value;
					else e.status = ST_RANGE;
				end
				CMD_INSERT: begin
					if (p > len) begin
						e.status = ST_RANGE;
					end else if (len >= CAPACITY) begin
						e.status = ST_FULL;
					end else begin
						for (int unsigned i = len; i > p; i--) words[i] = words[i - 1];
						words[p] = r.value;
						len++;
					end
				end
				CMD_REMOVE: begin
					if (p < len) begin
						for (int unsigned i = p; i + 1 < len; i++) words[i] = words[i + 1];
						words[len - 1] = '0;
						len--;
					end else begin
						e.status = ST_RANGE;
					end
				end
				CMD_RESIZE: begin
					if (p > CAPACITY) begin
						e.status = ST_FULL;
					end else begin
						if (p < len) zero_from(p);
						len = p;
					end
				end
				CMD_CLEAR: begin
					zero_from(0);
					len = 0;
				end
				CMD_REALLOC: begin
					if (p > CAPACITY) begin
						e.status = ST_FULL;
					end else begin
						zero_from(0);
						len = p;
					end
				end
				default: ;
			endcase
			e.length = len[6:0];
			pending.push_back(e);
		endfunction

		function void compare_field(string field, logic [31:0] expected, logic [31:0] actual);
			if (expected !== actual) begin
				$display("%0t: %s mismatch, expected %h, actual %h", $time, field, expected,
					actual);
				errors++;
			end
		endfunction

		function void check_result(rsp_t r);
			rsp_t e;
			if (pending.size() == 0) begin
				$display("%0t: result with none expected, actual %h", $time, r);
				errors++;
			end else begin
				e = pending.pop_front();
				compare_field("read_value", e.read_value, r.read_value);
				compare_field("length", 32'(e.length), 32'(r.length));
				compare_field("status", 32'(e.status), 32'(r.status));
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	array_scoreboard sb;
	int req_idle_pct;
	int rsp_idle_pct;
	int hold_request;

	indexed_array_insert_remove i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready) sb.note_request(req);
			if (rsp_valid && rsp_ready) sb.check_result(rsp);
		end
	end

	// result side: random back-pressure, plus one long hold when asked
	initial begin
		int hold_left;
		hold_left = 0;
		rsp_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left == 0 && hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
			else quiet++;
		end
		$display("Verification failed");
		$finish;
	end

	task automatic send(req_t r);
		while ($urandom_range(99) < req_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (!req_ready);
		@(negedge clk);
	endtask

	task automatic send_cmd(logic [2:0] c, int unsigned p, logic [31:0] v);
		req_t r;
		r.cmd = c;
		r.position = 7'(p);
		r.value = v;
		send(r);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(negedge clk);
		while (sb.pending.size() != 0) @(negedge clk);
	endtask

	function automatic req_t random_request();
		req_t r;
		int unsigned pick;
		int unsigned n;
		n = sb.len;
		r.value = $urandom;
		r.cmd = CMD_READ;
		r.position = '0;
		if ($urandom_range(99) < 10) begin
			r.cmd = 3'($urandom_range(7));
			r.position = 7'($urandom_range(127));
		end else begin
			pick = $urandom_range(99);
			if (pick < 25) r.cmd = CMD_READ;
			else if (pick < 45) r.cmd = CMD_WRITE;
			else if (pick < 72) r.cmd = CMD_INSERT;
			else if (pick < 87) r.cmd = CMD_REMOVE;
			else if (pick < 93) r.cmd = CMD_RESIZE;
			else if (pick < 96) r.cmd = CMD_CLEAR;
			else r.cmd = CMD_REALLOC;
			case (r.cmd)
				CMD_INSERT: r.position = 7'($urandom_range(n));
				CMD_RESIZE, CMD_REALLOC: r.position = 7'($urandom_range(CAPACITY));
				CMD_CLEAR: r.position = 7'($urandom_range(127));
				default: r.position = (n == 0) ? 7'd0 : 7'($urandom_range(n - 1));
			endcase
		end
		return r;
	endfunction

	task automatic random_phase();
		repeat (ITEMS_PER_PHASE) send(random_request());
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		req_idle_pct = 15;
		rsp_idle_pct = 71;
		hold_request = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty array corners
		send_cmd(CMD_READ, 0, 32'h1234_5678);
		send_cmd(CMD_WRITE, 0, 32'hFFFF_FFFF);
		send_cmd(CMD_REMOVE, 0, 32'h0);
		send_cmd(CMD_INSERT, 1, 32'h5);
		// append, front insert, append at length
		send_cmd(CMD_INSERT, 0, 32'h7FFF_FFFF);
		send_cmd(CMD_INSERT, 0, 32'h8000_0000);
		send_cmd(CMD_INSERT, 2, 32'hFFFF_FFFF);
		send_cmd(CMD_READ, 0, 32'h0);
		send_cmd(CMD_READ, 2, 32'h0);
		send_cmd(CMD_WRITE, 1, 32'h0);
		send_cmd(CMD_REMOVE, 0, 32'h0);
		// growth reads zero, then shrink
		send_cmd(CMD_RESIZE, 5, 32'h0);
		send_cmd(CMD_READ, 4, 32'h0);
		send_cmd(CMD_RESIZE, 1, 32'h0);
		send_cmd(CMD_CLEAR, 127, 32'hDEAD_BEEF);
		send_cmd(CMD_UNUSED, 127, 32'hFFFF_FFFF);
		// full array
		send_cmd(CMD_REALLOC, CAPACITY, 32'h0);
		send_cmd(CMD_INSERT, CAPACITY, 32'h1);
		send_cmd(CMD_INSERT, 10, 32'h2);
		send_cmd(CMD_INSERT, CAPACITY + 1, 32'h3);
		send_cmd(CMD_RESIZE, CAPACITY + 1, 32'h0);
		send_cmd(CMD_REALLOC, 127, 32'h0);
		send_cmd(CMD_REMOVE, CAPACITY - 1, 32'h0);
		send_cmd(CMD_READ, CAPACITY - 1, 32'h0);
		send_cmd(CMD_REALLOC, 0, 32'h0);

		random_phase();
		drain();

		req_idle_pct = 71;
		rsp_idle_pct = 15;
		random_phase();
		drain();

		req_idle_pct = 0;
		rsp_idle_pct = 0;
		hold_request = LONG_HOLD;
		random_phase();
		drain();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
